### design/mwfr_pkg.sv
`timescale 1ns / 1ps

package mwfr_pkg;

    // Result status codes as they appear on the status port.
    typedef enum logic [2:0] {
        ST_SINGLE_OK  = 3'd0,
        ST_MULTI_HDR  = 3'd1,
        ST_MULTI_DATA = 3'd2,
        ST_CRC_ERR    = 3'd3,
        ST_TOO_LONG   = 3'd4
    } status_t;

    // Frame parser modes.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FUNC   = 2'd1,
        MODE_SINGLE = 2'd2,
        MODE_MULTI  = 2'd3
    } mode_t;

    // Result sequencer states.
    typedef enum logic [1:0] {
        RP_IDLE = 2'd0,
        RP_READ = 2'd1,
        RP_WAIT = 2'd2
    } rp_state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_STATION = 2'd0;
    localparam logic [1:0] REG_SINGLE  = 2'd1;
    localparam logic [1:0] REG_MULTI   = 2'd2;

    localparam logic [7:0] STATION_RESET = 8'd1;
    localparam logic [7:0] SINGLE_RESET  = 8'd6;
    localparam logic [7:0] MULTI_RESET   = 8'd16;

    // Byte positions within a frame (the address byte is position 0).
    localparam logic [15:0] POS_REG_HI     = 16'd2;
    localparam logic [15:0] POS_REG_LO     = 16'd3;
    localparam logic [15:0] POS_BODY       = 16'd4;
    localparam logic [15:0] POS_COUNT_LO   = 16'd5;
    localparam logic [15:0] POS_MULTI_DATA = 16'd6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Event handed from the frame parser to the result sequencer.
    typedef struct packed {
        status_t     status;
        logic [15:0] reg_addr;
        logic [7:0]  value;
        logic [15:0] count;
    } ev_t;

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/mwfr_ram.sv
`timescale 1ns / 1ps

module mwfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mwfr_ctrl.sv
`timescale 1ns / 1ps

module mwfr_ctrl import mwfr_pkg::*; #(
    parameter int MAX_DATA = 32,
    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    input  logic [7:0]    station_address,
    input  logic [7:0]    single_write_code,
    input  logic [7:0]    multi_write_code,
    input  logic          rp_busy,
    input  logic          ev_take,
    output logic          ev_valid,
    output ev_t           ev,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata
);

    // Position never exceeds the last CRC byte of the longest accepted frame.
    localparam int PW = $clog2(MAX_DATA + 9);

    mode_t        mode_reg,  mode_next;
    logic [PW-1:0] pos_reg,  pos_next;
    logic [15:0]  crc_reg,   crc_next;
    logic [7:0]   rlo_reg,   rlo_next;
    logic [15:0]  start_reg, start_next;
    logic [15:0]  count_reg, count_next;
    logic [7:0]   sval_reg,  sval_next;
    logic         ev_valid_reg;
    ev_t          ev_reg;

    logic         accept;
    logic         ev_set;
    ev_t          ev_new;
    logic [15:0]  pos16;
    logic [15:0]  crc_upd;
    logic [15:0]  cnt_new;
    logic [15:0]  end16;
    logic [15:0]  rx_crc;
    logic [15:0]  waddr_wide;
    logic         too_long;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = ev_valid_reg || rp_busy;
    assign pos16      = {{(16 - PW){1'b0}}, pos_reg};
    assign crc_upd    = crc_feed(crc_reg, rx_byte);
    assign cnt_new    = {count_reg[7:0], rx_byte};
    assign end16      = count_reg + POS_MULTI_DATA;
    assign rx_crc     = {rx_byte, rlo_reg};
    assign waddr_wide = pos16 - POS_MULTI_DATA;
    assign too_long   = (pos16 == POS_COUNT_LO) && (cnt_new > 16'(MAX_DATA));

    // Frame mode transitions.
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (frame_start)
            begin
                mode_next = (rx_byte == station_address) ? MODE_FUNC : MODE_IDLE;
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    MODE_FUNC:
                    begin
                        if (rx_byte == single_write_code)
                        begin
                            mode_next = MODE_SINGLE;
                        end
                        else if (rx_byte == multi_write_code)
                        begin
                            mode_next = MODE_MULTI;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SINGLE:
                    begin
                        if (pos16 >= POS_MULTI_DATA)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_MULTI:
                    begin
                        if (too_long || (pos16 > end16))
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // Frame fields, CRC, buffer writes and result events.
    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rlo_next   = rlo_reg;
        start_next = start_reg;
        count_next = count_reg;
        sval_next  = sval_reg;
        ram_we     = 1'b0;
        ev_set     = 1'b0;
        ev_new     = '{status: ST_SINGLE_OK, reg_addr: start_reg, value: 8'd0, count: 16'd0};
        if (accept)
        begin
            if (frame_start)
            begin
                pos_next   = PW'(1);
                crc_next   = crc_feed(CRC_INIT, rx_byte);
                rlo_next   = 8'd0;
                start_next = 16'd0;
                count_next = 16'd0;
                sval_next  = 8'd0;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                pos_next = pos_reg + PW'(1);
                if (mode_reg == MODE_FUNC)
                begin
                    crc_next = crc_upd;
                end
                else if ((pos16 == POS_REG_HI) || (pos16 == POS_REG_LO))
                begin
                    crc_next   = crc_upd;
                    start_next = {start_reg[7:0], rx_byte};
                end
                else if (mode_reg == MODE_SINGLE)
                begin
                    if (pos16 == POS_BODY)
                    begin
                        crc_next  = crc_upd;
                        sval_next = rx_byte;
                    end
                    else if (pos16 == POS_COUNT_LO)
                    begin
                        rlo_next = rx_byte;
                    end
                    else
                    begin
                        ev_set = 1'b1;
                        if (rx_crc == crc_reg)
                        begin
                            ev_new.status = ST_SINGLE_OK;
                            ev_new.value  = sval_reg;
                        end
                        else
                        begin
                            ev_new.status = ST_CRC_ERR;
                        end
                    end
                end
                else
                begin
                    if ((pos16 == POS_BODY) || (pos16 == POS_COUNT_LO))
                    begin
                        crc_next   = crc_upd;
                        count_next = cnt_new;
                        if (too_long)
                        begin
                            ev_set        = 1'b1;
                            ev_new.status = ST_TOO_LONG;
                            ev_new.count  = cnt_new;
                        end
                    end
                    else if (pos16 < end16)
                    begin
                        crc_next = crc_upd;
                        ram_we   = 1'b1;
                    end
                    else if (pos16 == end16)
                    begin
                        rlo_next = rx_byte;
                    end
                    else
                    begin
                        ev_set        = 1'b1;
                        ev_new.status = (rx_crc == crc_reg) ? ST_MULTI_HDR : ST_CRC_ERR;
                        ev_new.count  = count_reg;
                    end
                end
            end
        end
    end

    assign ram_waddr = waddr_wide[AW-1:0];
    assign ram_wdata = rx_byte;
    assign ev_valid  = ev_valid_reg;
    assign ev        = ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            rlo_reg      <= 8'd0;
            start_reg    <= 16'd0;
            count_reg    <= 16'd0;
            sval_reg     <= 8'd0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rlo_reg   <= rlo_next;
            start_reg <= start_next;
            count_reg <= count_next;
            sval_reg  <= sval_next;
            if (ev_set)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (ev_take)
            begin
                ev_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_set)
        begin
            ev_reg <= ev_new;
        end
    end

endmodule

### design/mwfr_replay.sv
`timescale 1ns / 1ps

module mwfr_replay import mwfr_pkg::*; #(
    parameter int MAX_DATA = 32,
    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ev_valid,
    input  ev_t           ev,
    output logic          ev_take,
    output logic          rp_busy,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    status,
    output logic [15:0]   reg_address,
    output logic [7:0]    value,
    output logic [15:0]   byte_count,
    output logic          last
);

    localparam int IW = $clog2(MAX_DATA + 1);

    rp_state_t     state_reg, state_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] cnt_reg;
    logic [15:0]   regaddr_reg;
    logic          out_valid_reg;
    status_t       status_reg;
    logic [15:0]   reg_address_reg;
    logic [7:0]    value_reg;
    logic [15:0]   byte_count_reg;
    logic          last_reg;

    logic          slot_free;
    logic          idx_last;
    logic          load_data;
    logic          has_data;

    assign slot_free = !out_valid_reg || !out_stall;
    assign idx_last  = (idx_reg + IW'(1)) == cnt_reg;
    assign has_data  = (ev.status == ST_MULTI_HDR) && (ev.count != 16'd0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RP_IDLE:
            begin
                if (ev_valid && slot_free && has_data)
                begin
                    state_next = RP_READ;
                end
            end
            RP_READ:
            begin
                state_next = RP_WAIT;
            end
            RP_WAIT:
            begin
                if (slot_free)
                begin
                    state_next = idx_last ? RP_IDLE : RP_READ;
                end
            end
            default:
            begin
                state_next = RP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ev_take   = (state_reg == RP_IDLE) && ev_valid && slot_free;
        ram_re    = (state_reg == RP_READ);
        load_data = (state_reg == RP_WAIT) && slot_free;
        rp_busy   = (state_reg != RP_IDLE);
    end

    assign ram_raddr = idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ev_take || load_data)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            idx_reg         <= '0;
            cnt_reg         <= ev.count[IW-1:0];
            regaddr_reg     <= ev.reg_addr;
            status_reg      <= ev.status;
            reg_address_reg <= ev.reg_addr;
            value_reg       <= ev.value;
            byte_count_reg  <= ev.count;
            last_reg        <= !has_data;
        end
        else if (load_data)
        begin
            idx_reg         <= idx_reg + IW'(1);
            status_reg      <= ST_MULTI_DATA;
            reg_address_reg <= regaddr_reg;
            value_reg       <= ram_rdata;
            byte_count_reg  <= {{(16 - IW){1'b0}}, idx_reg};
            last_reg        <= idx_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign reg_address = reg_address_reg;
    assign value       = value_reg;
    assign byte_count  = byte_count_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    // While data bytes are being replayed the index stays inside the frame.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != RP_IDLE) |-> (idx_reg < cnt_reg))
        else $error("replay index beyond data count");

    // A result that is not the last of its frame is always followed by more work.
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (state_reg != RP_IDLE))
        else $error("non-final result with sequencer idle");

    // The parser must not raise a new event while a frame is being replayed.
    a_no_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rp_busy |-> !ev_valid)
        else $error("event raised during replay");

    // Buffer data is only taken after a read has been issued.
    a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RP_WAIT && $past(state_reg) != RP_WAIT) |-> $past(ram_re))
        else $error("buffer data used without a read");
`endif

endmodule

### design/modbus_write_frame_receiver.sv
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// cfg       cfg_we                   cfg_index, cfg_data
// input     in_valid / in_stall      rx_byte, frame_start
// output    out_valid / out_stall    status, reg_address, value, byte_count, last
//
// A frame byte is taken whenever it is valid and not stalled. After a byte that
// ends a frame with a result, input is stalled while the event passes to the
// sequencer. A good multi write sends its header via the event and output
// registers, then each data item by a buffer read (RP_READ) and load (RP_WAIT).
// Input is stalled for the whole replay; an output stall holds the sequencer.
// Reset clears all control state; the data buffer needs no clearing pass.
module modbus_write_frame_receiver import mwfr_pkg::*; #(
    parameter int MAX_DATA = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] reg_address,
    output logic [7:0]  value,
    output logic [15:0] byte_count,
    output logic        last
);

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
    logic [7:0] station_reg;
    logic [7:0] single_reg;
    logic [7:0] multi_reg;

    // Parser to sequencer hand-over.
    logic          ev_valid;
    ev_t           ev;
    logic          ev_take;
    logic          rp_busy;

    // Data buffer ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
            single_reg  <= SINGLE_RESET;
            multi_reg   <= MULTI_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STATION:
                begin
                    station_reg <= cfg_data;
                end
                REG_SINGLE:
                begin
                    single_reg <= cfg_data;
                end
                REG_MULTI:
                begin
                    multi_reg <= cfg_data;
                end
                default:
                begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // The parser follows the frame byte by byte, keeps the running CRC and
    // writes multi write data into the buffer.
    mwfr_ctrl #(
        .MAX_DATA (MAX_DATA)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .station_address   (station_reg),
        .single_write_code (single_reg),
        .multi_write_code  (multi_reg),
        .rp_busy           (rp_busy),
        .ev_take           (ev_take),
        .ev_valid          (ev_valid),
        .ev                (ev),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata)
    );

    // The buffer holds the data bytes of one multi write frame.
    mwfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The sequencer turns each event into results and replays buffered data
    // through the output register.
    mwfr_replay #(
        .MAX_DATA (MAX_DATA)
    ) u_replay (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_valid    (ev_valid),
        .ev          (ev),
        .ev_take     (ev_take),
        .rp_busy     (rp_busy),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .reg_address (reg_address),
        .value       (value),
        .byte_count  (byte_count),
        .last        (last)
    );

endmodule
